@@ hw/rtl/cslo_pkg.sv @@
package cslo_pkg;

	// Field widths of items and results.
	localparam int START_W  = 10;
	localparam int LEN_W    = 7;
	localparam int FB_REG_W = 7;
	localparam int MASK_W   = 32;
	localparam int IDX_W    = 5;
	localparam int CNT_W    = 6;

	// Walk position: wide enough for a start of 511 plus a long Motorola climb.
	localparam int POS_W = 12;

	// Motorola step at a byte boundary, to the MSB of the next byte.
	localparam logic signed [POS_W-1:0] MOTO_JUMP = 12'sd15;

	// Reset payload length in bytes.
	localparam logic [FB_REG_W-1:0] FRAME_BYTES_RESET = 7'd8;

	// Index reported for a signal beyond the capacity of the owner masks.
	localparam logic [IDX_W-1:0] FULL_INDEX = 5'd31;

	// Depth of the descriptor queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Classified descriptor handed from the front to the back.
	typedef struct packed {
		logic signed [START_W-1:0] start;
		logic [LEN_W-1:0]          len;
		logic                      intel;
		logic                      last;
		logic                      bad_len;
		logic                      neg;
		logic                      past;
	} desc_t;

	// One result item.
	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic              bad_len;
		logic              neg;
		logic              past;
		logic              outside;
		logic [MASK_W-1:0] mask;
		logic              too_many;
		logic              eom;
	} res_t;

endpackage

@@ hw/rtl/cslo_ram.sv @@
module cslo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read sees the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/cslo_front.sv @@
module cslo_front #(
	parameter int FB_W = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [cslo_pkg::START_W-1:0]  start_bit,
	input  logic [cslo_pkg::LEN_W-1:0]           signal_length,
	input  logic                                 byte_order,
	input  logic                                 last_signal,
	input  logic [FB_W-1:0]                      frame_bits,
	input  logic                                 hold,
	output logic                                 q_valid,
	output cslo_pkg::desc_t                      q_data,
	input  logic                                 q_pop
);

	localparam int PTR_W = $clog2(cslo_pkg::QUEUE_DEPTH);
	localparam int QC_W  = $clog2(cslo_pkg::QUEUE_DEPTH + 1);

	cslo_pkg::desc_t       entry_q [cslo_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [QC_W-1:0]       count_q;
	cslo_pkg::desc_t       desc;
	logic                  accept;
	logic                  take;
	logic [11:0]           end_sum;

	// Classify the descriptor as it arrives.
	always_comb begin
		end_sum      = 12'({2'b00, start_bit}) + 12'(signal_length);
		desc.start   = start_bit;
		desc.len     = signal_length;
		desc.intel   = byte_order;
		desc.last    = last_signal;
		desc.bad_len = (signal_length == '0);
		desc.neg     = !desc.bad_len && start_bit[cslo_pkg::START_W-1];
		desc.past    = !desc.bad_len && !desc.neg && byte_order &&
		               (end_sum > 12'(frame_bits));
	end

	assign full    = (count_q == QC_W'(cslo_pkg::QUEUE_DEPTH)) || hold;
	assign accept  = push && !full;
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];
	assign take    = q_pop && q_valid;

	// Short queue of classified items towards the back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(cslo_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(cslo_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !accept) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= desc;
		end
	end

endmodule

@@ hw/rtl/cslo_back.sv @@
module cslo_back #(
	parameter int MAX_FRAME_BYTES = 64,
	parameter int MAX_SIGNALS     = 32,
	parameter int FB_W            = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FB_W-1:0]   frame_bits,
	input  logic              q_valid,
	input  cslo_pkg::desc_t   q_data,
	output logic              q_pop,
	output logic              init_busy,
	output logic              empty,
	input  logic              pop,
	output cslo_pkg::res_t    res
);

	localparam int STORE_DEPTH = MAX_FRAME_BYTES * 8;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CAPACITY    = (MAX_SIGNALS > 32) ? 32 : MAX_SIGNALS;
	localparam int POS_W       = cslo_pkg::POS_W;
	localparam int MASK_W      = cslo_pkg::MASK_W;
	localparam int CNT_W       = cslo_pkg::CNT_W;
	localparam int LEN_W       = cslo_pkg::LEN_W;

	localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
	localparam logic [AW:0]      DEPTH_C = (AW+1)'(STORE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT,
		ST_CLEAR
	} state_t;

	state_t                    state_q;
	cslo_pkg::desc_t           cur_q;
	logic signed [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]          left_q;
	logic [LEN_W-1:0]          inside_q;
	logic [MASK_W-1:0]         mask_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [AW:0]               hi_q;
	logic [AW:0]               clr_q;
	logic                      init_q;
	logic                      out_valid_q;
	cslo_pkg::res_t            out_q;
	logic                      valid_s1;
	logic [AW-1:0]             addr_s1;
	logic                      fwd_valid_q;
	logic [AW-1:0]             fwd_addr_q;
	logic [MASK_W-1:0]         fwd_data_q;

	logic                      full_sig;
	logic [MASK_W-1:0]         own;
	logic                      in_frame;
	logic [AW-1:0]             rd_addr;
	logic [AW:0]               rd_end;
	logic [MASK_W-1:0]         rd_data;
	logic [MASK_W-1:0]         cur_word;
	logic [MASK_W-1:0]         new_word;
	logic                      clr_more;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [MASK_W-1:0]         wr_data;
	logic                      out_ready;
	cslo_pkg::res_t            res_next;

	// Owner bit of the current signal; none once the capacity is reached.
	assign full_sig = (cnt_q >= CAP_C);
	assign own      = full_sig ? '0 : (MASK_W'(1) << cnt_q[cslo_pkg::IDX_W-1:0]);

	// Walk step: is the current position inside the frame.
	assign in_frame = (state_q == ST_WALK) && (left_q != '0) && !pos_q[POS_W-1] &&
	                  (pos_q[POS_W-2:0] < (POS_W-1)'(frame_bits));
	assign rd_addr  = pos_q[AW-1:0];
	assign rd_end   = {1'b0, rd_addr} + 1'b1;

	// Read-modify-write of the owner word; bypass the word written in the previous cycle.
	assign cur_word = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;
	assign new_word = cur_word | own;

	// Write port shared by the walk and the clearing sweep.
	assign clr_more = (clr_q < hi_q);
	assign wr_en    = valid_s1 || ((state_q == ST_CLEAR) && clr_more);
	assign wr_addr  = valid_s1 ? addr_s1 : clr_q[AW-1:0];
	assign wr_data  = valid_s1 ? new_word : '0;

	cslo_ram #(
		.WIDTH (MASK_W),
		.DEPTH (STORE_DEPTH)
	) u_owner_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (in_frame),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result of the finished walk.
	always_comb begin
		res_next.index    = full_sig ? cslo_pkg::FULL_INDEX :
		                    cnt_q[cslo_pkg::IDX_W-1:0];
		res_next.bad_len  = cur_q.bad_len;
		res_next.neg      = cur_q.neg;
		res_next.past     = cur_q.past;
		res_next.outside  = (inside_q < cur_q.len);
		res_next.mask     = mask_q;
		res_next.too_many = full_sig;
		res_next.eom      = cur_q.last;
	end

	assign out_ready = !out_valid_q || pop;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = init_q;
	assign empty     = !out_valid_q;
	assign res       = out_q;

	// Sequencer: walk the bit positions, report, and clear the store after a message and after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			hi_q        <= DEPTH_C;
			clr_q       <= '0;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_frame;
			fwd_valid_q <= valid_s1;
			if (pop && out_valid_q && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s1) begin
				mask_q <= mask_q | (cur_word & ~own);
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q    <= q_data;
						pos_q    <= POS_W'(q_data.start);
						left_q   <= q_data.len;
						inside_q <= '0;
						mask_q   <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (left_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						left_q <= left_q - 1'b1;
						if (in_frame) begin
							inside_q <= inside_q + 1'b1;
							if (rd_end > hi_q) begin
								hi_q <= rd_end;
							end
						end
						if (cur_q.intel) begin
							pos_q <= pos_q + 1'b1;
						end else if (pos_q[2:0] == 3'd0) begin
							pos_q <= pos_q + cslo_pkg::MOTO_JUMP;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_next;
						if (cur_q.last) begin
							cnt_q   <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							if (!full_sig) begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					if (clr_more) begin
						clr_q <= clr_q + 1'b1;
					end else begin
						hi_q    <= '0;
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline address and bypass payload need no reset.
	always_ff @(posedge clk) begin
		addr_s1    <= rd_addr;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_word;
	end

endmodule

@@ hw/rtl/can_signal_layout_overlap_checker_unit.sv @@
// An item at the walker passes through ST_WALK, ST_DRAIN and ST_RESULT in that order;
// the walk steps once per signal bit and reads the owner store for each bit in the frame.
// The walker takes a new item only after it has reported the last one. After a last
// signal the store is cleared up to the highest bit position used.
// Reset: asynchronous, active low; the store is then cleared in full, with full held
// high; frame_bytes returns to 8.
module can_signal_layout_overlap_checker_unit #(
	parameter int MAX_FRAME_BYTES = 64,
	parameter int MAX_SIGNALS     = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [cslo_pkg::START_W-1:0]  start_bit,
	input  logic [cslo_pkg::LEN_W-1:0]           signal_length,
	input  logic                                 byte_order,
	input  logic                                 last_signal,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [cslo_pkg::IDX_W-1:0]           signal_index,
	output logic                                 bad_length,
	output logic                                 negative_start,
	output logic                                 intel_past_end,
	output logic                                 outside_frame,
	output logic [cslo_pkg::MASK_W-1:0]          overlap_mask,
	output logic                                 too_many_signals,
	output logic                                 end_of_message,
	input  logic                                 cfg_wr_en,
	input  logic [cslo_pkg::FB_REG_W-1:0]        cfg_wr_data
);

	localparam int FB_W = $clog2(MAX_FRAME_BYTES * 8 + 1);
	localparam logic [cslo_pkg::FB_REG_W-1:0] MAX_FB_C =
		cslo_pkg::FB_REG_W'(MAX_FRAME_BYTES);

	logic [cslo_pkg::FB_REG_W-1:0] frame_bytes_q;
	logic [cslo_pkg::FB_REG_W-1:0] fb_eff;
	logic [FB_W-1:0]               frame_bits;
	logic                          hold;
	logic                          q_valid;
	logic                          q_pop;
	cslo_pkg::desc_t               q_data;
	cslo_pkg::res_t                res;

	// Payload length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bytes_q <= cslo_pkg::FRAME_BYTES_RESET;
		end else if (cfg_wr_en) begin
			frame_bytes_q <= cfg_wr_data;
		end
	end

	// An oversized frame acts as the largest supported one.
	assign fb_eff     = (frame_bytes_q > MAX_FB_C) ? MAX_FB_C : frame_bytes_q;
	assign frame_bits = FB_W'({fb_eff, 3'b000});

	cslo_front #(
		.FB_W (FB_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.start_bit     (start_bit),
		.signal_length (signal_length),
		.byte_order    (byte_order),
		.last_signal   (last_signal),
		.frame_bits    (frame_bits),
		.hold          (hold),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop)
	);

	cslo_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.MAX_SIGNALS     (MAX_SIGNALS),
		.FB_W            (FB_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_bits (frame_bits),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.init_busy  (hold),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign signal_index     = res.index;
	assign bad_length       = res.bad_len;
	assign negative_start   = res.neg;
	assign intel_past_end   = res.past;
	assign outside_frame    = res.outside;
	assign overlap_mask     = res.mask;
	assign too_many_signals = res.too_many;
	assign end_of_message   = res.eom;

`ifndef ASSERT_OFF
	// A signal only ever overlaps signals stored before it in the message.
	a_mask_earlier_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !too_many_signals) |-> ((overlap_mask >> signal_index) == '0))
		else $error("overlap mask names the signal itself or a later one");

	// A signal beyond capacity carries the fixed index.
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && too_many_signals) |-> (signal_index == cslo_pkg::FULL_INDEX))
		else $error("signal beyond capacity reported with a stored index");

	// A zero-length signal covers no bit.
	a_zero_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_length) |->
		(overlap_mask == '0 && !outside_frame && !negative_start && !intel_past_end))
		else $error("zero-length signal reported covered bits");

	// Items are refused while the store is cleared after reset.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> full)
		else $error("item accepted during the initial store clear");
`endif

endmodule

@@ tb/sv/tb_can_signal_layout_overlap_checker_unit.sv @@
module tb_can_signal_layout_overlap_checker_unit;

	localparam int FRAME_MAX     = 64;
	localparam int SIGNAL_CAP    = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 600;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int STORE_AW      = $clog2(FRAME_MAX * 8);

	// Byte order codes as carried on the byte_order port.
	localparam logic MOTOROLA = 1'b0;
	localparam logic INTEL    = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [cslo_pkg::START_W-1:0] start_bit = '0;
	logic [cslo_pkg::LEN_W-1:0] signal_length = '0;
	logic byte_order = 1'b0;
	logic last_signal = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [cslo_pkg::IDX_W-1:0] signal_index;
	logic bad_length;
	logic negative_start;
	logic intel_past_end;
	logic outside_frame;
	logic [cslo_pkg::MASK_W-1:0] overlap_mask;
	logic too_many_signals;
	logic end_of_message;
	logic cfg_wr_en = 1'b0;
	logic [cslo_pkg::FB_REG_W-1:0] cfg_wr_data = '0;

	// Predictor state: owner masks per frame bit, signals in the open message, frame size.
	logic [cslo_pkg::MASK_W-1:0] owner_bits [FRAME_MAX*8];
	int msg_signals = 0;
	int frame_setting = 8;

	cslo_pkg::res_t expected_reports [$];
	cslo_pkg::res_t want;

	bit sender_idling = 1'b0;
	bit receiver_idling = 1'b0;
	bit hold_off_request = 1'b0;

	int failures = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int results_checked = 0;
	int overlaps_seen = 0;
	int over_capacity_seen = 0;

	can_signal_layout_overlap_checker_unit #(
		.MAX_FRAME_BYTES(FRAME_MAX),
		.MAX_SIGNALS(SIGNAL_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.start_bit(start_bit),
		.signal_length(signal_length),
		.byte_order(byte_order),
		.last_signal(last_signal),
		.empty(empty),
		.pop(pop),
		.signal_index(signal_index),
		.bad_length(bad_length),
		.negative_start(negative_start),
		.intel_past_end(intel_past_end),
		.outside_frame(outside_frame),
		.overlap_mask(overlap_mask),
		.too_many_signals(too_many_signals),
		.end_of_message(end_of_message),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame size in bits, with oversized settings capped at the largest frame.
	function automatic int frame_bits_now();
		return (frame_setting > FRAME_MAX ? FRAME_MAX : frame_setting) * 8;
	endfunction

	// Walks the bits of one signal through the owner store and works out its report.
	function automatic cslo_pkg::res_t walk_signal(
			logic signed [cslo_pkg::START_W-1:0] start, logic [cslo_pkg::LEN_W-1:0] len,
			logic order, logic last);
		int frame_bits, s, l, pos, p, covered;
		logic [cslo_pkg::MASK_W-1:0] own, shared;
		logic at_capacity;
		cslo_pkg::res_t r;
		frame_bits = frame_bits_now();
		s = int'(start);
		l = int'(len);
		at_capacity = (msg_signals >= SIGNAL_CAP);
		own = at_capacity ? '0 : (32'd1 << msg_signals);
		shared = '0;
		covered = 0;
		pos = s;
		for (int k = 0; k < l; k++) begin
			p = (order == INTEL) ? s + k : pos;
			if (p >= 0 && p < frame_bits) begin
				shared |= owner_bits[p[STORE_AW-1:0]] & ~own;
				owner_bits[p[STORE_AW-1:0]] |= own;
				covered++;
			end
			// Motorola goes down within a byte and jumps to the MSB of the next one.
			if (order == MOTOROLA)
				pos = ((pos & 7) == 0) ? pos + 15 : pos - 1;
		end
		r.index = at_capacity ? cslo_pkg::FULL_INDEX : msg_signals[cslo_pkg::IDX_W-1:0];
		r.bad_len = (l == 0);
		r.neg = (l != 0) && (s < 0);
		r.past = (l != 0) && (s >= 0) && (order == INTEL) && (s + l > frame_bits);
		r.outside = (covered < l);
		r.mask = shared;
		r.too_many = at_capacity;
		r.eom = last;
		if (!at_capacity)
			msg_signals++;
		if (last) begin
			foreach (owner_bits[i])
				owner_bits[i] = '0;
			msg_signals = 0;
		end
		return r;
	endfunction

	// Offers one item and records its expected report once it is taken.
	task automatic send_signal(input logic signed [cslo_pkg::START_W-1:0] start,
			input logic [cslo_pkg::LEN_W-1:0] len, input logic order, input logic last);
		push <= 1'b1;
		start_bit <= start;
		signal_length <= len;
		byte_order <= order;
		last_signal <= last;
		do @(posedge clk); while (full);
		expected_reports.push_back(walk_signal(start, len, order, last));
		items_sent++;
		if (last)
			messages_sent++;
		if (sender_idling && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Stops offering items and waits for every outstanding report.
	task automatic wait_for_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Writes the frame size once the block is idle and any store clearing is over.
	task automatic write_frame_bytes(input int value);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[cslo_pkg::FB_REG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frame_setting = value;
	endtask

	// Mostly signals that sit in the frame, with some wholly random descriptors.
	task automatic pick_signal(output logic signed [cslo_pkg::START_W-1:0] s,
			output logic [cslo_pkg::LEN_W-1:0] l, output logic o);
		int bits;
		bits = frame_bits_now();
		o = 1'($urandom_range(0, 1));
		if (bits == 0 || $urandom_range(0, 7) == 0) begin
			s = cslo_pkg::START_W'($urandom_range(0, 1023));
			l = cslo_pkg::LEN_W'($urandom_range(0, 127));
		end else begin
			s = cslo_pkg::START_W'($urandom_range(0, bits - 1));
			l = ($urandom_range(0, 5) == 0) ? cslo_pkg::LEN_W'($urandom_range(1, 64)) :
			                                  cslo_pkg::LEN_W'($urandom_range(1, 12));
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", field, exp_val, got_val);
			failures++;
		end
	endtask

	// At the reset frame of 8 bytes: overlaps, both byte orders and field extremes.
	task automatic test_reset_frame_and_field_extremes();
		send_signal(10'sd0, 7'd8, INTEL, 1'b0);
		send_signal(10'sd4, 7'd8, INTEL, 1'b0);
		send_signal(10'sd7, 7'd4, MOTOROLA, 1'b0);
		send_signal(10'sd56, 7'd9, INTEL, 1'b0);
		send_signal(-10'sd1, 7'd4, INTEL, 1'b0);
		send_signal(-10'sd512, 7'd0, MOTOROLA, 1'b0);
		send_signal(10'sd511, 7'd127, MOTOROLA, 1'b0);
		send_signal(10'sd0, 7'd127, INTEL, 1'b1);
	endtask

	// Largest frame: Motorola and Intel signals over the first 8 bytes, and the top bit position.
	task automatic test_full_frame_walks();
		write_frame_bytes(FRAME_MAX);
		send_signal(10'sd7, 7'd64, MOTOROLA, 1'b0);
		send_signal(10'sd0, 7'd64, INTEL, 1'b0);
		send_signal(10'sd511, 7'd1, INTEL, 1'b0);
		send_signal(10'sd511, 7'd2, INTEL, 1'b0);
		send_signal(10'sd504, 7'd16, MOTOROLA, 1'b1);
	endtask

	// A frame of no bytes leaves every bit outside.
	task automatic test_empty_frame();
		write_frame_bytes(0);
		send_signal(10'sd0, 7'd1, INTEL, 1'b0);
		send_signal(10'sd0, 7'd0, INTEL, 1'b1);
	endtask

	// The largest register value acts as the largest frame.
	task automatic test_oversized_frame();
		write_frame_bytes(127);
		send_signal(10'sd511, 7'd1, MOTOROLA, 1'b0);
		send_signal(10'sd500, 7'd20, INTEL, 1'b0);
		send_signal(-10'sd8, 7'd20, MOTOROLA, 1'b1);
	endtask

	// One message with more signals than the owner masks can hold.
	task automatic test_signal_capacity();
		write_frame_bytes(8);
		for (int i = 0; i < 36; i++)
			send_signal(cslo_pkg::START_W'($urandom_range(0, 63)),
				cslo_pkg::LEN_W'($urandom_range(1, 4)), 1'($urandom_range(0, 1)),
				i == 35);
	endtask

	// The receiver holds off while items keep coming, so the block fills and stalls.
	task automatic test_receiver_hold();
		logic signed [cslo_pkg::START_W-1:0] s;
		logic [cslo_pkg::LEN_W-1:0] l;
		logic o;
		sender_idling = 1'b0;
		hold_off_request = 1'b1;
		for (int i = 0; i < 24; i++) begin
			pick_signal(s, l, o);
			send_signal(s, l, o, i == 23);
		end
		wait_for_results();
	endtask

	// The sender stops mid-message until every report is back, then carries on.
	task automatic test_sender_drain_pause();
		logic signed [cslo_pkg::START_W-1:0] s;
		logic [cslo_pkg::LEN_W-1:0] l;
		logic o;
		sender_idling = 1'b1;
		receiver_idling = 1'b1;
		for (int i = 0; i < 20; i++) begin
			if (i == 10)
				wait_for_results();
			pick_signal(s, l, o);
			send_signal(s, l, o, i == 19);
		end
	endtask

	// Whole messages of random signals, now and then one beyond the capacity.
	task automatic test_random_messages(input int frame, input int count);
		int sent, msg_len;
		logic signed [cslo_pkg::START_W-1:0] s;
		logic [cslo_pkg::LEN_W-1:0] l;
		logic o;
		write_frame_bytes(frame);
		sent = 0;
		while (sent < count) begin
			sender_idling = ($urandom_range(0, 3) != 0);
			receiver_idling = ($urandom_range(0, 3) != 0);
			msg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 36) :
			                                         $urandom_range(1, 8);
			for (int i = 0; i < msg_len; i++) begin
				pick_signal(s, l, o);
				send_signal(s, l, o, i == msg_len - 1);
			end
			sent += msg_len;
		end
	endtask

	// Back-to-back items with the receiver always ready.
	task automatic test_steady_stream();
		logic signed [cslo_pkg::START_W-1:0] s;
		logic [cslo_pkg::LEN_W-1:0] l;
		logic o;
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		for (int i = 0; i < 80; i++) begin
			pick_signal(s, l, o);
			send_signal(s, l, o, (i % 6 == 5) || i == 79);
		end
	endtask

	// The receiver pops at random, and holds off for a long stretch when asked.
	initial begin
		int held;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				pop <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_off_request = 1'b0;
				pop <= 1'b1;
			end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Each report taken is compared with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (expected_reports.size() == 0) begin
				$error("Report with no item pending: signal_index %0d", signal_index);
				failures++;
			end else begin
				want = expected_reports.pop_front();
				check_field("signal_index", want.index, signal_index);
				check_field("bad_length", want.bad_len, bad_length);
				check_field("negative_start", want.neg, negative_start);
				check_field("intel_past_end", want.past, intel_past_end);
				check_field("outside_frame", want.outside, outside_frame);
				check_field("overlap_mask", want.mask, overlap_mask);
				check_field("too_many_signals", want.too_many, too_many_signals);
				check_field("end_of_message", want.eom, end_of_message);
				if (want.mask != '0)
					overlaps_seen++;
				if (want.too_many)
					over_capacity_seen++;
			end
		end
	end

	// Guards against a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL can_signal_layout_overlap_checker_unit");
			$finish;
		end
	end

	initial begin
		foreach (owner_bits[i])
			owner_bits[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame_and_field_extremes();
		test_full_frame_walks();
		test_empty_frame();
		test_oversized_frame();
		test_signal_capacity();
		test_receiver_hold();
		test_sender_drain_pause();
		test_random_messages(8, 170);
		test_random_messages(1, 170);
		test_random_messages(FRAME_MAX, 170);
		test_random_messages($urandom_range(0, 127), 170);
		write_frame_bytes(8);
		test_steady_stream();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d signals in %0d messages over frame sizes of 0 to 127 bytes;",
			items_sent, messages_sent);
		$display("%0d reports checked, %0d with shared bits, %0d beyond the capacity.",
			results_checked, overlaps_seen, over_capacity_seen);
		if (failures == 0)
			$display("PASS can_signal_layout_overlap_checker_unit");
		else
			$display("FAIL can_signal_layout_overlap_checker_unit");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/cslo_pkg.sv
hw/rtl/cslo_ram.sv
hw/rtl/cslo_front.sv
hw/rtl/cslo_back.sv
hw/rtl/can_signal_layout_overlap_checker_unit.sv
tb/sv/tb_can_signal_layout_overlap_checker_unit.sv
